[rtl/sbs_pkg.sv]
// Shared types, constants and helper functions of the save block scrambler.
// Used by the register block, controller, datapath and top level; no dependencies.
package sbs_pkg;

   // File store geometry.
   localparam int MAX_BYTES = 32768;
   localparam int ADDR_W    = $clog2(MAX_BYTES);
   localparam int LEN_W     = ADDR_W + 1;
   localparam int OFF_W     = 15;
   localparam int CMP_W     = ((LEN_W > OFF_W) ? LEN_W : OFF_W) + 1;

   // Fixed positions and keys of the scheme.
   localparam logic [LEN_W-1:0] SEED_SLOT   = LEN_W'(8'h45);
   localparam logic [LEN_W-1:0] SHIFT_LIMIT = LEN_W'(8'h46);
   localparam logic [7:0]       SEED_KEY    = 8'hC3;

   // Register map indexes.
   localparam logic CSR_DIRECTION  = 1'b0;
   localparam logic CSR_CHK_OFFSET = 1'b1;

   // Input item function codes.
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_FETCH = 1'b1;

   typedef enum logic [2:0] {
      IDX_HOLD, IDX_ZERO, IDX_INC, IDX_DEC, IDX_BODY, IDX_BODY_M1, IDX_SLOT
   } idx_op_type;

   typedef enum logic [2:0] {
      RD_IDX, RD_IDX_M1, RD_IDX_P1, RD_TGT, RD_SLOT, RD_PTR
   } rd_sel_type;

   typedef enum logic [2:0] {
      WA_IDX, WA_TGT, WA_OFF, WA_OFF1, WA_SLOT, WA_BODY
   } wa_sel_type;

   typedef enum logic [2:0] {
      WD_ZERO, WD_SUM_LO, WD_SUM_HI, WD_INV, WD_RDATA, WD_RPAD, WD_A, WD_SEEDKEY
   } wd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       new_file;
      logic       fetch;
      idx_op_type idx_op;
      rd_sel_type rd_sel;
      logic       wr_en;
      wa_sel_type wa_sel;
      wd_sel_type wd_sel;
      logic       sum_clr;
      logic       sum_acc;
      logic       seed_clr;
      logic       seed_acc;
      logic       seed_load;
      logic       a_cap;
      logic       a_pad;
      logic       res_fwd;
      logic       res_bwd;
      logic       res_inc;
      logic       res_dec;
      logic       mod_run;
      logic       set_short;
   } sbs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ovf;
      logic len_short;
      logic idx_lt_body;
      logic idx_gt_slot;
      logic idx_zero;
      logic body_gt_limit;
      logic mod_done;
   } sbs_stat_type;

   // Nine-entry pad.
   function automatic logic [7:0] pad_lookup(input logic [3:0] i);
      logic [7:0] v;
      case (i)
         4'd0:    v = 8'h55;
         4'd1:    v = 8'hC3;
         4'd2:    v = 8'h3A;
         4'd3:    v = 8'hCC;
         4'd4:    v = 8'hA5;
         4'd5:    v = 8'hAA;
         4'd6:    v = 8'h33;
         4'd7:    v = 8'h5A;
         4'd8:    v = 8'h3C;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // Seven-entry hop distances of the walk.
   function automatic logic [6:0] hop_lookup(input logic [2:0] i);
      logic [6:0] v;
      case (i)
         3'd0:    v = 7'h23;
         3'd1:    v = 7'h0D;
         3'd2:    v = 7'h17;
         3'd3:    v = 7'h01;
         3'd4:    v = 7'h1F;
         3'd5:    v = 7'h29;
         3'd6:    v = 7'h13;
         default: v = 7'h00;
      endcase
      return v;
   endfunction

   // Byte modulo 7: 8 is 1 modulo 7, so the octal digits are summed.
   function automatic logic [2:0] mod7_u8(input logic [7:0] x);
      logic [4:0] s;
      logic [4:0] r;
      s = 5'(x[7:6]) + 5'(x[5:3]) + 5'(x[2:0]);
      if (s >= 5'd14) begin
         r = s - 5'd14;
      end else if (s >= 5'd7) begin
         r = s - 5'd7;
      end else begin
         r = s;
      end
      return r[2:0];
   endfunction

   // Byte modulo 9: 64 is 1 and 8 is -1 modulo 9.
   function automatic logic [3:0] mod9_u8(input logic [7:0] x);
      logic [6:0] y;
      logic [5:0] z;
      logic [3:0] r;
      y = 7'(x[7:6]) + 7'(x[5:0]);
      z = y[6] ? (y[5:0] + 6'd1) : y[5:0];
      if (z[2:0] >= z[5:3]) begin
         r = 4'(z[2:0]) - 4'(z[5:3]);
      end else begin
         r = 4'(z[2:0]) + 4'd9 - 4'(z[5:3]);
      end
      return r;
   endfunction

endpackage

[rtl/sbs_csr.sv]
// Configuration registers (direction, checksum offset) behind an APB-style port.
// Depends on sbs_pkg.
module sbs_csr import sbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output logic             direction,
   output logic [OFF_W-1:0] checksum_offset
);

   logic             dir_ff;
   logic [OFF_W-1:0] off_ff;
   logic             wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite;

   // Register writes on the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= 1'b1;
         off_ff <= '0;
      end else if (wr_hit) begin
         case (csr_paddr[2])
            CSR_DIRECTION:  dir_ff <= csr_pwdata[0];
            CSR_CHK_OFFSET: off_ff <= csr_pwdata[OFF_W-1:0];
            default:        dir_ff <= dir_ff;
         endcase
      end
   end

   // Read data.
   always_comb begin
      case (csr_paddr[2])
         CSR_DIRECTION:  csr_prdata = {31'd0, dir_ff};
         CSR_CHK_OFFSET: csr_prdata = {{(32-OFF_W){1'b0}}, off_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign direction       = dir_ff;
   assign checksum_offset = off_ff;

endmodule

[rtl/sbs_ctrl.sv]
// Controller state machine that sequences loading, the scramble and unscramble
// passes and fetching. Depends on sbs_pkg; drives sbs_dp through sbs_cmd_type.
module sbs_ctrl import sbs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         req_func,
   input  logic         req_last,
   input  logic         direction,
   input  sbs_stat_type stat,
   output sbs_cmd_type  cmd,
   output logic         busy
);

   typedef enum logic [4:0] {
      ST_LOAD, ST_OUTPUT, ST_DECIDE,
      ST_CZ0, ST_CZ1, ST_SUM_RD, ST_SUM_AC, ST_CW0, ST_CW1,
      ST_INV_RD, ST_INV_WR, ST_MODPREP,
      ST_FW_RA, ST_FW_RB, ST_FW_WI, ST_FW_WT,
      ST_SH_RD, ST_SH_WR, ST_SH_SEED,
      ST_US_RD, ST_US_SEED, ST_UN_SH_RD, ST_UN_SH_WR,
      ST_BW_RA, ST_BW_RB, ST_BW_WI, ST_BW_WT, ST_UZERO
   } state_type;

   state_type state_ff, state_in;
   logic      dir_ff, dir_in;
   logic      accept;

   assign busy   = !(state_ff == ST_LOAD || state_ff == ST_OUTPUT);
   assign accept = start && !busy;

   // State and latched mode.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         dir_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         dir_ff   <= dir_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      dir_in   = dir_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD, ST_OUTPUT: begin
            if (accept) begin
               if (req_func == FUNC_LOAD) begin
                  cmd.load     = 1'b1;
                  cmd.new_file = (state_ff == ST_OUTPUT);
                  state_in     = req_last ? ST_DECIDE : ST_LOAD;
               end else if (state_ff == ST_OUTPUT) begin
                  cmd.fetch  = 1'b1;
                  cmd.rd_sel = RD_PTR;
               end
            end
         end
         ST_DECIDE: begin
            dir_in = direction;
            if (stat.ovf) begin
               state_in = ST_OUTPUT;
            end else if (!direction) begin
               state_in = ST_CZ0;
            end else if (stat.len_short) begin
               cmd.set_short = 1'b1;
               state_in      = ST_OUTPUT;
            end else begin
               state_in = ST_US_RD;
            end
         end
         // Scramble: clear the checksum field, sum the body, write the sum.
         ST_CZ0: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_OFF;
            cmd.wd_sel = WD_ZERO;
            state_in   = ST_CZ1;
         end
         ST_CZ1: begin
            cmd.wr_en   = 1'b1;
            cmd.wa_sel  = WA_OFF1;
            cmd.wd_sel  = WD_ZERO;
            cmd.idx_op  = IDX_ZERO;
            cmd.sum_clr = 1'b1;
            state_in    = ST_SUM_RD;
         end
         ST_SUM_RD: begin
            if (stat.idx_lt_body) begin
               cmd.rd_sel = RD_IDX;
               state_in   = ST_SUM_AC;
            end else begin
               state_in = ST_CW0;
            end
         end
         ST_SUM_AC: begin
            cmd.sum_acc = 1'b1;
            cmd.idx_op  = IDX_INC;
            state_in    = ST_SUM_RD;
         end
         ST_CW0: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_OFF;
            cmd.wd_sel = WD_SUM_LO;
            state_in   = ST_CW1;
         end
         ST_CW1: begin
            cmd.wr_en    = 1'b1;
            cmd.wa_sel   = WA_OFF1;
            cmd.wd_sel   = WD_SUM_HI;
            cmd.idx_op   = IDX_ZERO;
            cmd.seed_clr = 1'b1;
            state_in     = ST_INV_RD;
         end
         // Inversion pass, shared by both directions; scramble also builds the seed.
         ST_INV_RD: begin
            if (stat.idx_lt_body) begin
               cmd.rd_sel = RD_IDX;
               state_in   = ST_INV_WR;
            end else if (dir_ff) begin
               state_in = ST_OUTPUT;
            end else begin
               cmd.res_fwd = 1'b1;
               cmd.idx_op  = IDX_ZERO;
               state_in    = ST_MODPREP;
            end
         end
         ST_INV_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.wa_sel   = WA_IDX;
            cmd.wd_sel   = WD_INV;
            cmd.seed_acc = 1'b1;
            cmd.idx_op   = IDX_INC;
            state_in     = ST_INV_RD;
         end
         // Reduce the hop offsets modulo the body length.
         ST_MODPREP: begin
            cmd.mod_run = 1'b1;
            if (stat.mod_done) begin
               state_in = dir_ff ? ST_BW_RA : ST_FW_RA;
            end
         end
         // Forward walk: swap with the target, padding the value moved down.
         ST_FW_RA: begin
            if (stat.idx_lt_body) begin
               cmd.rd_sel = RD_IDX;
               state_in   = ST_FW_RB;
            end else if (stat.body_gt_limit) begin
               cmd.idx_op = IDX_BODY;
               state_in   = ST_SH_RD;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_FW_RB: begin
            cmd.a_cap  = 1'b1;
            cmd.rd_sel = RD_TGT;
            state_in   = ST_FW_WI;
         end
         ST_FW_WI: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_IDX;
            cmd.wd_sel = WD_RPAD;
            state_in   = ST_FW_WT;
         end
         ST_FW_WT: begin
            cmd.wr_en   = 1'b1;
            cmd.wa_sel  = WA_TGT;
            cmd.wd_sel  = WD_A;
            cmd.idx_op  = IDX_INC;
            cmd.res_inc = 1'b1;
            state_in    = ST_FW_RA;
         end
         // Shift the tail up by one and plant the keyed seed.
         ST_SH_RD: begin
            if (stat.idx_gt_slot) begin
               cmd.rd_sel = RD_IDX_M1;
               state_in   = ST_SH_WR;
            end else begin
               state_in = ST_SH_SEED;
            end
         end
         ST_SH_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_IDX;
            cmd.wd_sel = WD_RDATA;
            cmd.idx_op = IDX_DEC;
            state_in   = ST_SH_RD;
         end
         ST_SH_SEED: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_SLOT;
            cmd.wd_sel = WD_SEEDKEY;
            state_in   = ST_OUTPUT;
         end
         // Unscramble: recover the seed and shift the tail down.
         ST_US_RD: begin
            cmd.rd_sel = RD_SLOT;
            state_in   = ST_US_SEED;
         end
         ST_US_SEED: begin
            cmd.seed_load = 1'b1;
            cmd.idx_op    = IDX_SLOT;
            state_in      = ST_UN_SH_RD;
         end
         ST_UN_SH_RD: begin
            if (stat.idx_lt_body) begin
               cmd.rd_sel = RD_IDX_P1;
               state_in   = ST_UN_SH_WR;
            end else begin
               cmd.res_bwd = 1'b1;
               cmd.idx_op  = IDX_BODY_M1;
               state_in    = ST_MODPREP;
            end
         end
         ST_UN_SH_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_IDX;
            cmd.wd_sel = WD_RDATA;
            cmd.idx_op = IDX_INC;
            state_in   = ST_UN_SH_RD;
         end
         // Backward walk undoes the forward swaps from the top down.
         ST_BW_RA: begin
            cmd.rd_sel = RD_IDX;
            state_in   = ST_BW_RB;
         end
         ST_BW_RB: begin
            cmd.a_cap  = 1'b1;
            cmd.a_pad  = 1'b1;
            cmd.rd_sel = RD_TGT;
            state_in   = ST_BW_WI;
         end
         ST_BW_WI: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_IDX;
            cmd.wd_sel = WD_RDATA;
            state_in   = ST_BW_WT;
         end
         ST_BW_WT: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_TGT;
            cmd.wd_sel = WD_A;
            if (stat.idx_zero) begin
               state_in = ST_UZERO;
            end else begin
               cmd.idx_op  = IDX_DEC;
               cmd.res_dec = 1'b1;
               state_in    = ST_BW_RA;
            end
         end
         ST_UZERO: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_BODY;
            cmd.wd_sel = WD_ZERO;
            cmd.idx_op = IDX_ZERO;
            state_in   = ST_INV_RD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

[rtl/sbs_dp.sv]
// Datapath: file store memory, length and fetch pointer, index, residues,
// sums, seed, hop-offset reduction and result registers. Depends on sbs_pkg.
module sbs_dp import sbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  sbs_cmd_type      cmd,
   input  logic [7:0]       req_data_byte,
   input  logic [OFF_W-1:0] checksum_offset,
   output sbs_stat_type     stat,
   output logic             rsp_valid,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_last,
   output logic             rsp_error
);

   // File store.
   logic [7:0] mem [MAX_BYTES];
   logic [7:0] rdata_ff;

   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] ptr_ff, ptr_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [2:0]       len7_ff, len7_in;
   logic [3:0]       len9_ff, len9_in;
   logic [2:0]       cs7_ff, cs7_in;
   logic [3:0]       cs9_ff, cs9_in;
   logic [3:0]       p9_ff, p9_in;
   logic             ovf_ff, ovf_in;
   logic             short_ff, short_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       seed_ff, seed_in;
   logic [7:0]       a_ff;
   logic             valid_ff, valid_in;
   logic             olast_ff, olast_in;
   logic             oerr_ff, oerr_in;

   // Hop offsets reduced modulo the body length.
   logic [LEN_W-1:0] km_ff [7];
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [2:0]       mj_ff;
   logic [2:0]       mb_ff;

   logic [LEN_W-1:0] body;
   logic [LEN_W-1:0] len_base;
   logic             full;
   logic [LEN_W:0]   tsum;
   logic [LEN_W-1:0] tgt;
   logic [LEN_W-1:0] rd_addr;
   logic [LEN_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic             wr_ok;
   logic [7:0]       pad_cs;
   logic [6:0]       mod_val;
   logic [LEN_W:0]   mod_r2;
   logic [LEN_W:0]   mod_r;
   logic [2:0]       b7;
   logic [3:0]       b9;
   logic [3:0]       s7;
   logic [4:0]       s9;
   logic             off_in_file;
   logic             off1_in_file;

   assign body   = len_ff - LEN_W'(1);
   assign pad_cs = pad_lookup(cs9_ff);

   // Walk target: reduced hop plus index, folded once into the body.
   assign tsum = {1'b0, km_ff[cs7_ff]} + {1'b0, idx_ff};
   assign tgt  = (tsum >= {1'b0, body}) ? LEN_W'(tsum - {1'b0, body}) : tsum[LEN_W-1:0];

   // Status toward the controller.
   assign stat.ovf           = ovf_ff;
   assign stat.len_short     = len_ff < SHIFT_LIMIT;
   assign stat.idx_lt_body   = idx_ff < body;
   assign stat.idx_gt_slot   = idx_ff > SEED_SLOT;
   assign stat.idx_zero      = idx_ff == '0;
   assign stat.body_gt_limit = body > SHIFT_LIMIT;
   assign stat.mod_done      = mj_ff == 3'd7;

   // Read address selection.
   always_comb begin
      case (cmd.rd_sel)
         RD_IDX:    rd_addr = idx_ff;
         RD_IDX_M1: rd_addr = idx_ff - LEN_W'(1);
         RD_IDX_P1: rd_addr = idx_ff + LEN_W'(1);
         RD_TGT:    rd_addr = tgt;
         RD_SLOT:   rd_addr = SEED_SLOT;
         RD_PTR:    rd_addr = ptr_ff;
         default:   rd_addr = idx_ff;
      endcase
   end

   // Write address, data and the checksum-in-file guard.
   assign len_base     = cmd.new_file ? '0 : len_ff;
   assign full         = len_base >= LEN_W'(MAX_BYTES);
   assign off_in_file  = CMP_W'(checksum_offset) < CMP_W'(len_ff);
   assign off1_in_file = (CMP_W'(checksum_offset) + CMP_W'(1)) < CMP_W'(len_ff);

   always_comb begin
      wr_ok = cmd.wr_en;
      case (cmd.wa_sel)
         WA_IDX:  wr_addr = idx_ff;
         WA_TGT:  wr_addr = tgt;
         WA_OFF: begin
            wr_addr = LEN_W'(checksum_offset);
            wr_ok   = cmd.wr_en && off_in_file;
         end
         WA_OFF1: begin
            wr_addr = LEN_W'(checksum_offset) + LEN_W'(1);
            wr_ok   = cmd.wr_en && off1_in_file;
         end
         WA_SLOT: wr_addr = SEED_SLOT;
         WA_BODY: wr_addr = body;
         default: wr_addr = idx_ff;
      endcase
      case (cmd.wd_sel)
         WD_ZERO:    wr_data = 8'h00;
         WD_SUM_LO:  wr_data = sum_ff[7:0];
         WD_SUM_HI:  wr_data = sum_ff[15:8];
         WD_INV:     wr_data = ~rdata_ff;
         WD_RDATA:   wr_data = rdata_ff;
         WD_RPAD:    wr_data = rdata_ff ^ pad_cs;
         WD_A:       wr_data = a_ff;
         WD_SEEDKEY: wr_data = seed_ff ^ SEED_KEY;
         default:    wr_data = 8'h00;
      endcase
      // A loaded byte takes the write port.
      if (cmd.load) begin
         wr_addr = len_base;
         wr_data = req_data_byte;
         wr_ok   = !full;
      end
   end

   // Memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_addr[ADDR_W-1:0]] <= wr_data;
      end
      rdata_ff <= mem[rd_addr[ADDR_W-1:0]];
   end

   // Length, flags and pointer.
   always_comb begin
      len_in   = len_ff;
      len7_in  = len7_ff;
      len9_in  = len9_ff;
      ovf_in   = ovf_ff;
      short_in = short_ff;
      ptr_in   = ptr_ff;
      valid_in = 1'b0;
      olast_in = 1'b0;
      oerr_in  = 1'b0;
      if (cmd.load) begin
         len_in   = len_base;
         len7_in  = cmd.new_file ? 3'd0 : len7_ff;
         len9_in  = cmd.new_file ? 4'd0 : len9_ff;
         ovf_in   = cmd.new_file ? 1'b0 : ovf_ff;
         short_in = cmd.new_file ? 1'b0 : short_ff;
         ptr_in   = cmd.new_file ? '0 : ptr_ff;
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            len_in  = len_base + LEN_W'(1);
            len7_in = (len7_in == 3'd6) ? 3'd0 : len7_in + 3'd1;
            len9_in = (len9_in == 4'd8) ? 4'd0 : len9_in + 4'd1;
         end
      end
      if (cmd.set_short) begin
         short_in = 1'b1;
      end
      if (cmd.fetch && ptr_ff < len_ff) begin
         valid_in = 1'b1;
         olast_in = (ptr_ff + LEN_W'(1)) == len_ff;
         oerr_in  = ovf_ff || short_ff;
         ptr_in   = ptr_ff + LEN_W'(1);
      end
   end

   // Index counter.
   always_comb begin
      case (cmd.idx_op)
         IDX_HOLD:    idx_in = idx_ff;
         IDX_ZERO:    idx_in = '0;
         IDX_INC:     idx_in = idx_ff + LEN_W'(1);
         IDX_DEC:     idx_in = idx_ff - LEN_W'(1);
         IDX_BODY:    idx_in = body;
         IDX_BODY_M1: idx_in = body - LEN_W'(1);
         IDX_SLOT:    idx_in = SEED_SLOT;
         default:     idx_in = idx_ff;
      endcase
   end

   // Residues of (index + seed) modulo 7 and 9, and the pad position.
   always_comb begin
      b7     = (len7_ff >= 3'd2) ? len7_ff - 3'd2 : len7_ff + 3'd5;
      b9     = (len9_ff >= 4'd2) ? len9_ff - 4'd2 : len9_ff + 4'd7;
      s7     = 4'(b7) + 4'(mod7_u8(seed_ff));
      s9     = 5'(b9) + 5'(mod9_u8(seed_ff));
      cs7_in = cs7_ff;
      cs9_in = cs9_ff;
      if (cmd.res_fwd) begin
         cs7_in = mod7_u8(seed_ff);
         cs9_in = mod9_u8(seed_ff);
      end else if (cmd.res_bwd) begin
         cs7_in = (s7 >= 4'd7) ? 3'(s7 - 4'd7) : s7[2:0];
         cs9_in = (s9 >= 5'd9) ? 4'(s9 - 5'd9) : s9[3:0];
      end else if (cmd.res_inc) begin
         cs7_in = (cs7_ff == 3'd6) ? 3'd0 : cs7_ff + 3'd1;
         cs9_in = (cs9_ff == 4'd8) ? 4'd0 : cs9_ff + 4'd1;
      end else if (cmd.res_dec) begin
         cs7_in = (cs7_ff == 3'd0) ? 3'd6 : cs7_ff - 3'd1;
         cs9_in = (cs9_ff == 4'd0) ? 4'd8 : cs9_ff - 4'd1;
      end
   end

   // Byte sum and seed accumulation.
   always_comb begin
      sum_in  = sum_ff;
      seed_in = seed_ff;
      p9_in   = p9_ff;
      if (cmd.sum_clr) begin
         sum_in = '0;
      end else if (cmd.sum_acc) begin
         sum_in = sum_ff + 16'(rdata_ff);
      end
      if (cmd.seed_clr) begin
         seed_in = '0;
         p9_in   = '0;
      end else if (cmd.seed_acc) begin
         seed_in = seed_ff + (pad_lookup(p9_ff) ^ ~rdata_ff);
         p9_in   = (p9_ff == 4'd8) ? 4'd0 : p9_ff + 4'd1;
      end else if (cmd.seed_load) begin
         seed_in = rdata_ff ^ SEED_KEY;
      end
   end

   // One restoring-remainder step per cycle, seven bits per hop value.
   assign mod_val = hop_lookup(mj_ff) + 7'(seed_ff[5:0]);
   assign mod_r2  = {rem_ff, mod_val[3'd6 - mb_ff]};
   assign mod_r   = (mod_r2 >= {1'b0, body}) ? mod_r2 - {1'b0, body} : mod_r2;
   assign rem_in  = mod_r[LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mj_ff  <= '0;
         mb_ff  <= '0;
         rem_ff <= '0;
      end else if (!cmd.mod_run) begin
         mj_ff  <= '0;
         mb_ff  <= '0;
         rem_ff <= '0;
      end else if (mj_ff != 3'd7) begin
         if (mb_ff == 3'd6) begin
            km_ff[mj_ff] <= rem_in;
            rem_ff       <= '0;
            mb_ff        <= '0;
            mj_ff        <= mj_ff + 3'd1;
         end else begin
            rem_ff <= rem_in;
            mb_ff  <= mb_ff + 3'd1;
         end
      end
   end

   // Control and status registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         len7_ff  <= '0;
         len9_ff  <= '0;
         ptr_ff   <= '0;
         idx_ff   <= '0;
         ovf_ff   <= 1'b0;
         short_ff <= 1'b0;
         valid_ff <= 1'b0;
         cs7_ff   <= '0;
         cs9_ff   <= '0;
         p9_ff    <= '0;
         sum_ff   <= '0;
         seed_ff  <= '0;
      end else begin
         len_ff   <= len_in;
         len7_ff  <= len7_in;
         len9_ff  <= len9_in;
         ptr_ff   <= ptr_in;
         idx_ff   <= idx_in;
         ovf_ff   <= ovf_in;
         short_ff <= short_in;
         valid_ff <= valid_in;
         cs7_ff   <= cs7_in;
         cs9_ff   <= cs9_in;
         p9_ff    <= p9_in;
         sum_ff   <= sum_in;
         seed_ff  <= seed_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.a_cap) begin
         a_ff <= cmd.a_pad ? (rdata_ff ^ pad_cs) : rdata_ff;
      end
      olast_ff <= olast_in;
      oerr_ff  <= oerr_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = rdata_ff;
   assign rsp_out_last = olast_ff;
   assign rsp_error    = oerr_ff;

endmodule

[rtl/save_block_scrambler_unit.sv]
// Top level of the save block scrambler: registers, controller and datapath.
// Depends on sbs_pkg, sbs_csr, sbs_ctrl and sbs_dp.
// Load: one byte per cycle; the last byte starts processing and raises busy. A scramble
// clears and sums the checksum field, inverts and seeds, reduces the hops, walks and, for
// long files, shifts in the keyed seed; an unscramble skips the sum and undoes the rest.
// Fetch: one per cycle, with the result strobe in the cycle after the fetch is accepted.
// Reset (synchronous) empties the file and restores direction=1, offset=0.
module save_block_scrambler_unit import sbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic        rsp_error,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic             direction;
   logic [OFF_W-1:0] checksum_offset;
   sbs_cmd_type      cmd;
   sbs_stat_type     stat;

   sbs_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .direction       (direction),
      .checksum_offset (checksum_offset)
   );

   sbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_func),
      .req_last  (req_last),
      .direction (direction),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   sbs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_data_byte   (req_data_byte),
      .checksum_offset (checksum_offset),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_last    (rsp_out_last),
      .rsp_error       (rsp_error)
   );

endmodule

[rtl/sbs_checker.sv]
// Port-level checks for save_block_scrambler_unit, attached by bind.
// Depends only on the top level's ports.
module sbs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_func,
   input logic req_last,
   input logic rsp_valid,
   input logic csr_pready
);

   // A result follows only an accepted fetch item.
   a_rsp_after_fetch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_func))
      else $error("result without a preceding fetch");

   // Processing starts only after the final byte of a file is loaded.
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !req_func && req_last))
      else $error("busy without a final load");

   // A result never appears while processing.
   a_no_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      busy && $past(busy) |-> !rsp_valid)
      else $error("result during processing");

   // Reset leaves the block idle with no result.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");

   // The register port never waits.
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready low");

endmodule

bind save_block_scrambler_unit sbs_checker u_sbs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_func   (req_func),
   .req_last   (req_last),
   .rsp_valid  (rsp_valid),
   .csr_pready (csr_pready)
);

[bench/tb_save_block_scrambler_unit.sv]
// Self-checking testbench of save_block_scrambler_unit: loads files, fetches them back
// and checks every fetched byte against a behavioral predictor. Depends on sbs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_save_block_scrambler_unit;
   import sbs_pkg::*;

   localparam logic [2:0] ADDR_DIRECTION  = 3'(CSR_DIRECTION) << 2;
   localparam logic [2:0] ADDR_CHK_OFFSET = 3'(CSR_CHK_OFFSET) << 2;
   localparam logic [7:0] PAD [9] = '{8'h55, 8'hC3, 8'h3A, 8'hCC, 8'hA5, 8'hAA, 8'h33,
                                      8'h5A, 8'h3C};
   localparam int unsigned HOP [7] = '{'h23, 'h0D, 'h17, 'h01, 'h1F, 'h29, 'h13};
   localparam int unsigned SLOT = 'h45;
   localparam int unsigned LIMIT = 'h46;

   typedef struct {
      logic [7:0] out_byte;
      logic       out_last;
      logic       error;
   } fetched_byte_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_func;
   logic [7:0]  req_data_byte;
   logic        req_last;
   logic        rsp_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_last;
   logic        rsp_error;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predicted file contents and control state.
   logic [7:0]       file_bytes [MAX_BYTES];
   int unsigned      file_len;
   int unsigned      fetch_ptr;
   logic [7:0]       seed;
   bit               in_output;
   bit               overflowed;
   bit               too_short;
   bit               dir_unscramble;
   int unsigned      chk_offset;
   fetched_byte_type bytes_due [$];
   int unsigned      failures;
   int unsigned      n_items;
   bit               gaps_on;

   save_block_scrambler_unit u_top (.*);

   always #5 clock = ~clock;

   // Store a byte only where it lies inside the file.
   function automatic void put_byte(int unsigned idx, logic [7:0] v);
      if (idx < file_len && idx < MAX_BYTES) file_bytes[idx] = v;
   endfunction

   function automatic int unsigned walk_dest(int unsigned i, int unsigned body);
      return (HOP[(i + seed) % 7] + (seed & 8'h3F) + i) % body;
   endfunction

   function automatic void scramble_file();
      int unsigned body;
      int unsigned t;
      logic [15:0] sum;
      logic [7:0]  acc;
      logic [7:0]  a;
      body = file_len - 1;
      sum = '0;
      acc = '0;
      put_byte(chk_offset, 8'h00);
      put_byte(chk_offset + 1, 8'h00);
      for (int unsigned i = 0; i < body; i++) sum += 16'(file_bytes[i]);
      put_byte(chk_offset, sum[7:0]);
      put_byte(chk_offset + 1, sum[15:8]);
      for (int unsigned i = 0; i < body; i++) file_bytes[i] = ~file_bytes[i];
      for (int unsigned i = 0; i < body; i++) acc += PAD[i % 9] ^ file_bytes[i];
      seed = acc;
      // Keyed swap-and-xor walk.
      for (int unsigned i = 0; i < body; i++) begin
         t = walk_dest(i, body);
         a = file_bytes[i];
         file_bytes[i] = file_bytes[t] ^ PAD[(i + seed) % 9];
         file_bytes[t] = a;
      end
      // Long files make room for the masked seed.
      if (body > LIMIT) begin
         for (int unsigned i = body; i > SLOT; i--) file_bytes[i] = file_bytes[i - 1];
         file_bytes[SLOT] = seed ^ PAD[1];
      end
   endfunction

   function automatic void unscramble_file();
      int unsigned body;
      int unsigned i;
      int unsigned t;
      logic [7:0]  a;
      body = file_len - 1;
      seed = PAD[1] ^ file_bytes[SLOT];
      for (int unsigned k = SLOT; k < body; k++) file_bytes[k] = file_bytes[k + 1];
      for (int unsigned k = body; k > 0; k--) begin
         i = k - 1;
         t = walk_dest(i, body);
         a = file_bytes[i] ^ PAD[(i + seed) % 9];
         file_bytes[i] = file_bytes[t];
         file_bytes[t] = a;
      end
      file_bytes[body] = 8'h00;
      for (int unsigned k = 0; k < body; k++) file_bytes[k] = ~file_bytes[k];
   endfunction

   // Advance the predicted state by one accepted item.
   function automatic void predict_item(logic f, logic [7:0] d, logic l);
      fetched_byte_type r;
      if (f == FUNC_LOAD) begin
         if (in_output) begin
            in_output = 0;
            file_len = 0;
            fetch_ptr = 0;
            overflowed = 0;
            too_short = 0;
         end
         if (file_len < MAX_BYTES) begin
            file_bytes[file_len] = d;
            file_len++;
         end else begin
            overflowed = 1;
         end
         if (l) begin
            in_output = 1;
            fetch_ptr = 0;
            if (!overflowed) begin
               if (!dir_unscramble) scramble_file();
               else if (file_len < LIMIT) too_short = 1;
               else unscramble_file();
            end
         end
      end else if (in_output && fetch_ptr < file_len && fetch_ptr < MAX_BYTES) begin
         r.out_byte = file_bytes[fetch_ptr];
         r.out_last = (fetch_ptr + 1 == file_len);
         r.error = overflowed || too_short;
         bytes_due.push_back(r);
         fetch_ptr++;
      end
   endfunction

   // Send one item and wait for it to be taken.
   task automatic send_item(logic f, logic [7:0] d, logic l);
      while (gaps_on && $urandom_range(99) < 31) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_func <= f;
      req_data_byte <= d;
      req_last <= l;
      do @(negedge clock); while (busy);
      @(posedge clock);
      predict_item(f, d, l);
      n_items++;
   endtask

   // Let every expected byte arrive and any processing finish.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] addr, logic [31:0] value);
      drain();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_DIRECTION) dir_unscramble = value[0];
      else chk_offset = value[14:0];
   endtask

   task automatic set_mode(bit unscramble, int unsigned offset);
      write_reg(ADDR_DIRECTION, 32'(unscramble));
      write_reg(ADDR_CHK_OFFSET, 32'(offset));
   endtask

   // Load a file of random bytes; fetch noise is mixed in at the given odds.
   task automatic load_file(int unsigned n, int unsigned noise_pct);
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(99) < noise_pct)
            send_item(FUNC_FETCH, 8'($urandom), 1'($urandom));
         send_item(FUNC_LOAD, 8'($urandom), i == n - 1);
      end
   endtask

   task automatic fetch_bytes(int unsigned n);
      repeat (n) send_item(FUNC_FETCH, 8'($urandom), 1'($urandom));
   endtask

   // Fetches with nothing loaded, short files in both directions, extreme bytes.
   task automatic test_directed();
      fetch_bytes(2);
      send_item(FUNC_LOAD, 8'h00, 1'b0);
      send_item(FUNC_FETCH, 8'hFF, 1'b1);
      send_item(FUNC_LOAD, 8'hFF, 1'b1);
      fetch_bytes(3);
      set_mode(0, 0);
      send_item(FUNC_LOAD, 8'hFF, 1'b1);
      fetch_bytes(2);
      send_item(FUNC_LOAD, 8'h00, 1'b0);
      send_item(FUNC_LOAD, 8'hFF, 1'b0);
      send_item(FUNC_LOAD, 8'h80, 1'b1);
      fetch_bytes(4);
      set_mode(0, 32766);
      send_item(FUNC_LOAD, 8'h7F, 1'b0);
      send_item(FUNC_LOAD, 8'h01, 1'b1);
      fetch_bytes(2);
   endtask

   // Long files: tail shift, checksum on the final byte, unscramble length bounds.
   task automatic test_long_files();
      set_mode(0, 79);
      load_file(80, 0);
      fetch_bytes(81);
      set_mode(1, 0);
      load_file(LIMIT, 0);
      fetch_bytes(LIMIT);
      load_file(LIMIT - 1, 0);
      fetch_bytes(LIMIT);
   endtask

   task automatic test_random();
      int unsigned goal;
      int unsigned n;
      goal = n_items + 200;
      while (n_items < goal) begin
         gaps_on = !(n_items > goal - 180 && n_items < goal - 60);
         if ($urandom_range(5) == 0) begin
            case ($urandom_range(3))
               0: n = 0;
               1: n = 32766;
               2: n = $urandom_range(0, 130);
               default: n = $urandom_range(0, 32766);
            endcase
            set_mode(1'($urandom_range(1)), n);
         end
         n = ($urandom_range(9) == 0) ? $urandom_range(70, 250) : $urandom_range(1, 100);
         load_file(n, 5);
         fetch_bytes(($urandom_range(4) == 0) ? $urandom_range(0, n) : n + 1);
         if ($urandom_range(6) == 0) drain();
      end
      gaps_on = 1;
   endtask

   // Compare each result with the oldest expected byte.
   always @(negedge clock) begin
      fetched_byte_type e;
      if (!reset && rsp_valid) begin
         if (bytes_due.size() == 0) begin
            $error("unexpected result: out_byte %h", rsp_out_byte);
            failures++;
         end else begin
            e = bytes_due.pop_front();
            if (rsp_out_byte !== e.out_byte) begin
               $error("out_byte expected %h actual %h", e.out_byte, rsp_out_byte);
               failures++;
            end
            if (rsp_out_last !== e.out_last) begin
               $error("out_last expected %b actual %b", e.out_last, rsp_out_last);
               failures++;
            end
            if (rsp_error !== e.error) begin
               $error("error expected %b actual %b", e.error, rsp_error);
               failures++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_func <= FUNC_LOAD;
      req_data_byte <= '0;
      req_last <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      file_len = 0;
      fetch_ptr = 0;
      seed = '0;
      in_output = 0;
      overflowed = 0;
      too_short = 0;
      dir_unscramble = 1;
      chk_offset = 0;
      failures = 0;
      n_items = 0;
      gaps_on = 1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_long_files();
      test_random();
      drain();
      repeat (20) @(posedge clock);
      if (failures == 0 && bytes_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
